// ===== sv/cnte_pkg.sv =====
// Package: shared tag codes and token types for the compact number token encoder.
`default_nettype none
package cnte_pkg;
	localparam int unsigned TokBytes = 9;

	localparam logic [7:0] TAG_U8  = 8'd27;
	localparam logic [7:0] TAG_U16 = 8'd28;
	localparam logic [7:0] TAG_U24 = 8'd29;
	localparam logic [7:0] TAG_U32 = 8'd30;
	localparam logic [7:0] TAG_RAW = 8'd31;
	localparam logic [7:0] TAG_NEG = 8'd32;

	localparam logic [10:0] EXP_BIAS = 11'd1023;
	localparam logic [10:0] EXP_MAX  = 11'd1054;

	typedef logic [63:0] value_t;
	typedef logic [7:0]  byte_t;
	typedef logic [3:0]  tok_len_t;

	typedef struct packed {
		logic [8*TokBytes-1:0] bytes;
		tok_len_t              len;
	} token_t;
endpackage
`default_nettype wire

// ===== sv/cnte_if.sv =====
// Interfaces: value request channel and token byte channel.
`default_nettype none
interface cnte_value_if;
	logic               valid;
	logic               ready;
	cnte_pkg::value_t   value_bits;

	modport source (output valid, output value_bits, input ready);
	modport sink   (input valid, input value_bits, output ready);
endinterface

interface cnte_byte_if;
	logic               valid;
	logic               ready;
	cnte_pkg::byte_t    out_byte;
	logic               last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/compact_number_token_encoder_core.sv =====
// Top level: compact number token encoder, double bit pattern to 1..9 byte token.
// Pipeline: three stages (field decode, magnitude extraction, token build) plus the
// byte output register, through which each request passes in order.
// Throughput: set by the byte-wide output register, which sends one byte per accepted
// beat; one-byte tokens sustain one value per cycle while token_ch.ready stays high.
// Reset clears all stage valid bits and the output byte count; payload is not reset.
`default_nettype none
module compact_number_token_encoder_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	cnte_value_if.sink     value_ch,
	cnte_byte_if.source    token_ch
);
	import cnte_pkg::*;

	// stage 1: field decode
	logic        valid_s1;
	value_t      bits_s1;
	logic        zero_s1;
	logic        range_s1;
	logic [4:0]  sh_s1;

	// stage 2: magnitude extraction
	logic        valid_s2;
	value_t      bits_s2;
	logic        whole_s2;
	logic        neg_s2;
	logic [31:0] mag_s2;

	// stage 3: token build
	logic        valid_s3;
	token_t      tok_s3;

	// output serializer
	logic [8*TokBytes-1:0] buf_q;
	tok_len_t              cnt_q;

	logic ready_s1, ready_s2, ready_s3, load_ok;

	assign load_ok  = (cnt_q == '0) || ((cnt_q == tok_len_t'(1)) && token_ch.ready);
	assign ready_s3 = !valid_s3 || load_ok;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign value_ch.ready = ready_s1;

	// stage 1
	logic [10:0] exp_in;
	logic [51:0] frac_in;
	assign exp_in  = value_ch.value_bits[62:52];
	assign frac_in = value_ch.value_bits[51:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= value_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && value_ch.valid) begin
			bits_s1  <= value_ch.value_bits;
			zero_s1  <= (exp_in == '0) && (frac_in == '0);
			range_s1 <= (exp_in >= EXP_BIAS) && (exp_in <= EXP_MAX);
			sh_s1    <= 5'(exp_in - EXP_BIAS);
		end
	end

	// stage 2
	logic [52:0] sig;
	logic [5:0]  drop;
	logic [52:0] low_mask;
	logic        low_zero;
	logic [31:0] mag_c;
	assign sig      = {1'b1, bits_s1[51:0]};
	assign drop     = 6'd52 - {1'b0, sh_s1};
	assign low_mask = (53'd1 << drop) - 53'd1;
	assign low_zero = (sig & low_mask) == '0;
	assign mag_c    = sig[52:21] >> (~sh_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			bits_s2  <= bits_s1;
			whole_s2 <= zero_s1 || (range_s1 && low_zero);
			neg_s2   <= bits_s1[63] && !zero_s1;
			mag_s2   <= zero_s1 ? '0 : mag_c;
		end
	end

	// stage 3
	token_t tok_c;
	byte_t  sign_tag;
	always_comb begin
		sign_tag = neg_s2 ? TAG_NEG : '0;
		tok_c    = '{bytes: '0, len: tok_len_t'(TokBytes)};
		if (!whole_s2) begin
			tok_c.bytes = {bits_s2, TAG_RAW};
			tok_c.len   = tok_len_t'(TokBytes);
		end else if (mag_s2 < 32'd27) begin
			tok_c.bytes = {64'd0, sign_tag | mag_s2[7:0]};
			tok_c.len   = tok_len_t'(1);
		end else if (mag_s2 < 32'd256) begin
			tok_c.bytes = {32'd0, mag_s2, sign_tag | TAG_U8};
			tok_c.len   = tok_len_t'(2);
		end else if (mag_s2 < 32'd65536) begin
			tok_c.bytes = {32'd0, mag_s2, sign_tag | TAG_U16};
			tok_c.len   = tok_len_t'(3);
		end else if (mag_s2 < 32'h0100_0000) begin
			tok_c.bytes = {32'd0, mag_s2, sign_tag | TAG_U24};
			tok_c.len   = tok_len_t'(4);
		end else begin
			tok_c.bytes = {32'd0, mag_s2, sign_tag | TAG_U32};
			tok_c.len   = tok_len_t'(5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			tok_s3 <= tok_c;
		end
	end

	// output serializer: load a whole token, shift out one byte per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_ok && valid_s3) begin
			cnt_q <= tok_s3.len;
		end else if (token_ch.valid && token_ch.ready) begin
			cnt_q <= cnt_q - tok_len_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && valid_s3) begin
			buf_q <= tok_s3.bytes;
		end else if (token_ch.valid && token_ch.ready) begin
			buf_q <= buf_q >> 8;
		end
	end

	assign token_ch.valid    = cnt_q != '0;
	assign token_ch.out_byte = buf_q[7:0];
	assign token_ch.last     = cnt_q == tok_len_t'(1);
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for compact_number_token_encoder_core: directed and random values checked byte by byte.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cnte_pkg::*;

	localparam int unsigned InlineLimit = 27;
	localparam int unsigned LongHold = 80;
	localparam int unsigned TailCycles = 16;
	localparam longint unsigned CycleLimit = 200000;

	typedef logic [8*TokBytes-1:0] tok_bytes_t;

	typedef struct packed {
		value_t                bits;
		logic                  typed;
		tok_len_t              len;
		logic [8*TokBytes-1:0] tok;
	} dir_row_t;

	logic clk;
	logic arst_n;

	cnte_value_if value_ch();
	cnte_byte_if  token_ch();

	compact_number_token_encoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_ch (value_ch),
		.token_ch (token_ch)
	);

	byte_t           due_byte[$];
	logic            due_last[$];
	dir_row_t        dir_rows[$];
	int unsigned     mismatches = 0;
	int unsigned     values_sent = 0;
	int unsigned     bytes_seen = 0;
	int unsigned     raw_tokens = 0;
	int unsigned     inline_tokens = 0;
	int unsigned     tagged_tokens = 0;
	longint unsigned cycles = 0;
	bit              tx_idle;
	bit              rx_idle;
	bit              long_hold_req;
	int unsigned     rx_idle_left;
	logic            at_header = 1'b1;
	byte_t           want_byte;
	logic            want_last;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void push_byte(byte_t b, logic l);
		due_byte.push_back(b);
		due_last.push_back(l);
	endfunction

	function automatic void encode_token(value_t v);
		logic [10:0] expo;
		logic [52:0] sig;
		int unsigned drop;
		logic        whole;
		logic [31:0] mag;
		byte_t       hdr;
		int unsigned n;
		expo = v[62:52];
		sig = {1'b1, v[51:0]};
		whole = 1'b0;
		mag = '0;
		n = 0;
		if (expo == '0) begin
			whole = (v[51:0] == '0);
		end else if (expo >= EXP_BIAS && expo <= EXP_MAX) begin
			drop = 32'd52 - 32'(expo - EXP_BIAS);
			whole = ((sig & ((53'd1 << drop) - 53'd1)) == '0);
			mag = 32'(sig >> drop);
		end
		if (!whole) begin
			push_byte(TAG_RAW, 1'b0);
			for (int i = 0; i < 8; i++)
				push_byte(v[8*i +: 8], i == 7);
		end else begin
			hdr = (v[63] && mag != '0) ? TAG_NEG : 8'd0;
			if (mag < InlineLimit) begin
				push_byte(hdr | mag[7:0], 1'b1);
			end else begin
				if (mag < 32'h100) begin
					hdr |= TAG_U8;
					n = 1;
				end else if (mag < 32'h10000) begin
					hdr |= TAG_U16;
					n = 2;
				end else if (mag < 32'h1000000) begin
					hdr |= TAG_U24;
					n = 3;
				end else begin
					hdr |= TAG_U32;
					n = 4;
				end
				push_byte(hdr, 1'b0);
				for (int i = 0; i < n; i++)
					push_byte(mag[8*i +: 8], i == n - 1);
			end
		end
	endfunction

	function automatic dir_row_t typed_row(value_t v, int unsigned n, tok_bytes_t t);
		dir_row_t r;
		r.bits = v;
		r.typed = 1'b1;
		r.len = tok_len_t'(n);
		r.tok = t;
		return r;
	endfunction

	function automatic dir_row_t plain_row(value_t v);
		dir_row_t r;
		r.bits = v;
		r.typed = 1'b0;
		r.len = '0;
		r.tok = '0;
		return r;
	endfunction

	function automatic value_t rand_value();
		value_t      v;
		logic [31:0] mag;
		int unsigned w;
		int unsigned pick;
		int unsigned sub;
		pick = $urandom_range(0, 9);
		w = $urandom_range(0, 32);
		mag = (w == 0) ? 32'd0 : ($urandom >> (32 - w));
		v = $realtobits(real'(mag));
		if ($urandom_range(0, 1) == 1)
			v[63] = 1'b1;
		case (pick)
			6: begin
				v[$urandom_range(0, 51)] ^= 1'b1;
			end
			7: begin
				v = {$urandom, $urandom};
			end
			8: begin
				sub = $urandom_range(0, 2);
				v[51:0] = ($urandom_range(0, 1) == 0) ? '0 : 52'({$urandom, $urandom});
				if (sub == 0)
					v[62:52] = '1;
				else if (sub == 1)
					v[62:52] = '0;
				else
					v[62:52] = 11'($urandom_range(1055, 2046));
			end
			9: begin
				v[62:52] = 11'($urandom_range(1000, 1060));
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	task automatic send_value(dir_row_t r);
		int unsigned gap;
		logic        taken;
		gap = 0;
		if (tx_idle && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		if (gap != 0) begin
			value_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value_ch.valid <= 1'b1;
		value_ch.value_bits <= r.bits;
		forever begin
			@(negedge clk);
			taken = value_ch.ready;
			@(posedge clk);
			if (taken)
				break;
		end
		if (r.typed) begin
			for (int k = 0; k < r.len; k++)
				push_byte(r.tok[8*k +: 8], k == r.len - 1);
		end else begin
			encode_token(r.bits);
		end
		values_sent++;
	endtask

	task automatic wait_token_drain();
		while (due_byte.size() != 0)
			@(posedge clk);
	endtask

	// receiver ready, with random stalls and the long hold-off
	initial begin
		token_ch.ready = 1'b0;
		rx_idle_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rx_idle_left = LongHold;
				token_ch.ready <= 1'b0;
			end else if (rx_idle_left != 0) begin
				rx_idle_left--;
				token_ch.ready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				rx_idle_left = $urandom_range(0, 7);
				token_ch.ready <= 1'b0;
			end else begin
				token_ch.ready <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && token_ch.valid && token_ch.ready) begin
			if (due_byte.size() == 0) begin
				mismatches++;
				$display("%0t: token byte %02h last %b arrived with nothing expected",
					$time, token_ch.out_byte, token_ch.last);
			end else begin
				want_byte = due_byte.pop_front();
				want_last = due_last.pop_front();
				if (want_byte !== token_ch.out_byte || want_last !== token_ch.last) begin
					mismatches++;
					$display("%0t: token byte mismatch: expected %02h last %b, actual %02h last %b",
						$time, want_byte, want_last, token_ch.out_byte, token_ch.last);
				end
				if (at_header) begin
					if (want_byte == TAG_RAW)
						raw_tokens++;
					else if ((want_byte & ~TAG_NEG) >= TAG_U8)
						tagged_tokens++;
					else
						inline_tokens++;
				end
				at_header = want_last;
				bytes_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("%0t: run stopped after %0d cycles with %0d token bytes still due",
				$time, cycles, due_byte.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		value_ch.valid = 1'b0;
		value_ch.value_bits = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		long_hold_req = 1'b0;

		dir_rows.push_back(typed_row(64'h0000000000000000, 1, tok_bytes_t'(8'd0)));
		dir_rows.push_back(typed_row(64'h8000000000000000, 1, tok_bytes_t'(8'd0)));
		dir_rows.push_back(typed_row(64'h3FF0000000000000, 1, tok_bytes_t'(8'd1)));
		dir_rows.push_back(typed_row(64'hBFF0000000000000, 1, tok_bytes_t'(TAG_NEG | 8'd1)));
		dir_rows.push_back(typed_row(64'h403A000000000000, 1, tok_bytes_t'(8'd26)));
		dir_rows.push_back(typed_row(64'hC03A000000000000, 1, tok_bytes_t'(TAG_NEG | 8'd26)));
		dir_rows.push_back(typed_row(64'h403B000000000000, 2, tok_bytes_t'({8'd27, TAG_U8})));
		dir_rows.push_back(typed_row(64'h406FE00000000000, 2, tok_bytes_t'({8'hFF, TAG_U8})));
		dir_rows.push_back(typed_row(64'h4070000000000000, 3,
			tok_bytes_t'({8'h01, 8'h00, TAG_U16})));
		dir_rows.push_back(plain_row(64'hC0EFFFE000000000));
		dir_rows.push_back(plain_row(64'h40F0000000000000));
		dir_rows.push_back(plain_row(64'hC16FFFFE00000000));
		dir_rows.push_back(plain_row(64'h4170000000000000));
		dir_rows.push_back(plain_row(64'h41EFFFFFFFE00000));
		dir_rows.push_back(plain_row(64'hC1EFFFFFFFE00000));
		dir_rows.push_back(typed_row(64'h41F0000000000000, 9, {64'h41F0000000000000, TAG_RAW}));
		dir_rows.push_back(plain_row(64'h41E0000000100000));
		dir_rows.push_back(typed_row(64'h3FE0000000000000, 9, {64'h3FE0000000000000, TAG_RAW}));
		dir_rows.push_back(plain_row(64'h3FF8000000000000));
		dir_rows.push_back(plain_row(64'h4008000000000001));
		dir_rows.push_back(typed_row(64'h0000000000000001, 9, {64'h0000000000000001, TAG_RAW}));
		dir_rows.push_back(typed_row(64'h7FF0000000000000, 9, {64'h7FF0000000000000, TAG_RAW}));
		dir_rows.push_back(typed_row(64'hFFF0000000000000, 9, {64'hFFF0000000000000, TAG_RAW}));
		dir_rows.push_back(typed_row(64'h7FF8000000000001, 9, {64'h7FF8000000000001, TAG_RAW}));
		dir_rows.push_back(typed_row(64'hFFFFFFFFFFFFFFFF, 9, {64'hFFFFFFFFFFFFFFFF, TAG_RAW}));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_value(dir_rows[i]);
		repeat (100) send_value(plain_row(rand_value()));

		// hold the token side off while requests keep coming
		long_hold_req = 1'b1;
		tx_idle = 1'b0;
		repeat (40) send_value(plain_row(rand_value()));
		tx_idle = 1'b1;
		value_ch.valid <= 1'b0;
		wait_token_drain();

		repeat (100) send_value(plain_row(rand_value()));

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (40) send_value(plain_row(rand_value()));
		value_ch.valid <= 1'b0;

		wait_token_drain();
		repeat (TailCycles) @(posedge clk);

		$display("Sent %0d values, checked %0d token bytes: %0d inline, %0d length-tagged, %0d raw",
			values_sent, bytes_seen, inline_tokens, tagged_tokens, raw_tokens);
		$display("Run included a long token-side hold-off, a drained pause and random idling");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
